### sv/box_muller_gaussian_pair_top_assert.svh
// Assertion macros shared by the Gaussian pair pipeline.
`ifndef BOX_MULLER_GAUSSIAN_PAIR_TOP_ASSERT_SVH
`define BOX_MULLER_GAUSSIAN_PAIR_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define BMG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BMG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/bmg_pkg.sv
package bmg_pkg;

	localparam int IN_BITS_DEF       = 32;
	localparam int OUT_FRAC_BITS_DEF = 12;
	localparam int VW_DEF            = $clog2(IN_BITS_DEF + 1) + 31;

	localparam int TW = 31;
	localparam logic [TW-1:0] Q30_ONE = TW'(64'd1 << 30);

	// 2 ln 2 in Q26
	localparam logic [26:0] TWO_LN2_Q26 = 27'd93032640;
	// 2 pi in Q30 minus 2^32
	localparam logic [31:0] TWO_PI_LO = 32'd2451551556;

	localparam int HSTEPS = 5;
	localparam int unsigned COS_DIV [HSTEPS] = '{90, 56, 30, 12, 2};
	// last sine step is the final multiply by x, divisor unused
	localparam int unsigned SIN_DIV [HSTEPS] = '{72, 42, 20, 6, 1};
	localparam logic [31:0] COS_RCP [HSTEPS] = '{
		32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 30),
		32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)};
	localparam logic [31:0] SIN_RCP [HSTEPS] = '{
		32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42), 32'((64'd1 << 32) / 20),
		32'((64'd1 << 32) / 6), 32'hFFFF_FFFF};

	typedef struct packed {
		logic [TW-1:0] m1;
		logic [TW-1:0] m2;
		logic          neg1;
	} trig_res_t;

endpackage

### sv/bmg_log.sv
module bmg_log #(
	parameter int IN_BITS = bmg_pkg::IN_BITS_DEF,
	parameter int SBW = 1,
	parameter int VW = bmg_pkg::VW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [IN_BITS-1:0] k,
	input  logic [SBW-1:0]     sb_in,
	output logic               out_valid,
	output logic [VW-1:0]      v,
	output logic [SBW-1:0]     sb_out
);
	import bmg_pkg::*;

	localparam int EW  = $clog2(IN_BITS);
	localparam int LW  = VW - 1;
	localparam int NSQ = 30;
	localparam int SW  = LW + 28;

	logic [IN_BITS-1:0]  kc, norm;
	logic [EW-1:0]       e0;
	logic [IN_BITS+30:0] ext;

	logic [NSQ+2:0]  vld_s;
	logic [30:0]     m_s [0:NSQ];
	logic [EW-1:0]   e_s [0:NSQ];
	logic [29:0]     f_s [0:NSQ];
	logic [SBW-1:0]  sb_s [0:NSQ+2];
	logic [30:0]     m_n [0:NSQ-1];
	logic            b_n [0:NSQ-1];

	logic [LW-1:0]   lval;
	logic [44:0]     plo_s;
	logic [LW+8:0]   phi_s;
	logic [SW-1:0]   sum;
	logic [VW-1:0]   v_s;

	// clamp, leading one, normalise to Q30
	always_comb begin
		kc = (k == '0) ? IN_BITS'(1) : k;
		e0 = '0;
		for (int i = 0; i < IN_BITS; i++) begin
			if (kc[i]) e0 = EW'(i);
		end
		norm = kc << (EW'(IN_BITS - 1) - e0);
		ext  = {norm, 31'd0};
	end

	// one squaring per stage, one fraction bit each
	always_comb begin
		logic [61:0] sq;
		logic [31:0] mm;
		for (int i = 0; i < NSQ; i++) begin
			sq     = 62'(m_s[i]) * 62'(m_s[i]);
			mm     = sq[61:30];
			b_n[i] = mm[31];
			m_n[i] = mm[31] ? mm[31:1] : mm[30:0];
		end
	end

	assign lval = (LW'(IN_BITS) << 30) - LW'({e_s[NSQ], f_s[NSQ]});
	assign sum  = SW'(plo_s) + (SW'(phi_s) << 18) + (SW'(1) << 25);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSQ+1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]  <= ext[IN_BITS+30 -: 31];
			e_s[0]  <= e0;
			f_s[0]  <= '0;
			sb_s[0] <= sb_in;
			for (int i = 0; i < NSQ; i++) begin
				m_s[i+1]  <= m_n[i];
				e_s[i+1]  <= e_s[i];
				f_s[i+1]  <= {f_s[i][28:0], b_n[i]};
				sb_s[i+1] <= sb_s[i];
			end
			plo_s         <= 45'(lval[17:0]) * 45'(TWO_LN2_Q26);
			phi_s         <= (LW+9)'(lval[LW-1:18]) * (LW+9)'(TWO_LN2_Q26);
			sb_s[NSQ+1]   <= sb_s[NSQ];
			v_s           <= sum[26 +: VW];
			sb_s[NSQ+2]   <= sb_s[NSQ+1];
		end
	end

	assign out_valid = vld_s[NSQ+2];
	assign v         = v_s;
	assign sb_out    = sb_s[NSQ+2];

endmodule

### sv/bmg_sqrt.sv
module bmg_sqrt #(
	parameter int VW = bmg_pkg::VW_DEF,
	parameter int SBW = 1,
	localparam int RW = (VW + 17) / 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [VW-1:0]  v,
	input  logic [SBW-1:0] sb_in,
	output logic           out_valid,
	output logic [RW-1:0]  r,
	output logic [SBW-1:0] sb_out
);
	import bmg_pkg::*;

	localparam int NW = 2 * RW;

	logic [RW:0]    vld_s;
	logic [NW-1:0]  n_s    [0:RW];
	logic [RW+1:0]  rem_s  [0:RW];
	logic [RW-1:0]  root_s [0:RW];
	logic [SBW-1:0] sb_s   [0:RW];
	logic [RW+1:0]  rem_n  [0:RW-1];
	logic [RW-1:0]  root_n [0:RW-1];

	// restoring square root, one result bit per stage
	always_comb begin
		logic [RW+3:0] cur, dsub;
		logic          ge;
		for (int i = 0; i < RW; i++) begin
			cur       = {rem_s[i], n_s[i][NW-1 -: 2]};
			dsub      = (RW+4)'({root_s[i], 2'b01});
			ge        = cur >= dsub;
			rem_n[i]  = ge ? (RW+2)'(cur - dsub) : (RW+2)'(cur);
			root_n[i] = {root_s[i][RW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[RW-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0]    <= NW'({v, 16'd0});
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			sb_s[0]   <= sb_in;
			for (int i = 0; i < RW; i++) begin
				n_s[i+1]    <= n_s[i] << 2;
				rem_s[i+1]  <= rem_n[i];
				root_s[i+1] <= root_n[i];
				sb_s[i+1]   <= sb_s[i];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign r         = root_s[RW];
	assign sb_out    = sb_s[RW];

endmodule

### sv/bmg_trig.sv
module bmg_trig #(
	parameter int SBW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [31:0]        a,
	input  logic [SBW-1:0]     sb_in,
	output logic               out_valid,
	output bmg_pkg::trig_res_t res,
	output logic [SBW-1:0]     sb_out
);
	import bmg_pkg::*;

	localparam int NH = 3 * HSTEPS;

	typedef struct packed {
		logic [TW-1:0] tc;
		logic [TW-1:0] ts;
		logic [TW-1:0] pc;
		logic [TW-1:0] ps;
		logic [TW-1:0] qc;
		logic [TW-1:0] qs;
	} horner_t;

	typedef struct packed {
		logic [TW-1:0] x;
		logic [TW-1:0] x2;
		logic [1:0]    q;
		logic          swap;
		logic          neg1;
	} tctl_t;

	logic [NH+3:0]  vld_s;
	logic [1:0]     q_s1;
	logic           swap_s1, neg1_s1;
	logic [29:0]    g_s1;
	logic [SBW-1:0] sb_s1, sb_s2;
	tctl_t          ctl_s2;
	logic [61:0]    xp;
	horner_t        hz_s  [0:NH];
	tctl_t          ctl_s [0:NH];
	logic [SBW-1:0] sb_s  [0:NH];
	horner_t        hz_n  [0:NH-1];
	trig_res_t      res_q_s;
	logic [SBW-1:0] sb_out_s;
	logic [TW-1:0]  cv, sv;

	assign xp = 62'(g_s1) * 62'(TWO_PI_LO);

	// Horner steps: multiply, reciprocal estimate, correct and subtract
	always_comb begin
		logic [31:0] rc, rs;
		for (int k = 0; k < NH; k++) begin
			hz_n[k] = hz_s[k];
		end
		for (int j = 0; j < HSTEPS; j++) begin
			hz_n[3*j].pc = TW'((62'(ctl_s[3*j].x2) * 62'(hz_s[3*j].tc)) >> 30);
			if (j < HSTEPS - 1) begin
				hz_n[3*j].ps = TW'((62'(ctl_s[3*j].x2) * 62'(hz_s[3*j].ts)) >> 30);
			end else begin
				hz_n[3*j].ps = TW'((62'(ctl_s[3*j].x) * 62'(hz_s[3*j].ts)) >> 30);
			end
			hz_n[3*j+1].qc = TW'((63'(hz_s[3*j+1].pc) * 63'(COS_RCP[j])) >> 32);
			hz_n[3*j+1].qs = TW'((63'(hz_s[3*j+1].ps) * 63'(SIN_RCP[j])) >> 32);
			rc = 32'(hz_s[3*j+2].pc) - 32'(hz_s[3*j+2].qc) * 32'(COS_DIV[j]);
			hz_n[3*j+2].tc = Q30_ONE - (hz_s[3*j+2].qc + TW'(rc >= 32'(COS_DIV[j])));
			if (j < HSTEPS - 1) begin
				rs = 32'(hz_s[3*j+2].ps) - 32'(hz_s[3*j+2].qs) * 32'(SIN_DIV[j]);
				hz_n[3*j+2].ts = Q30_ONE - (hz_s[3*j+2].qs + TW'(rs >= 32'(SIN_DIV[j])));
			end else begin
				hz_n[3*j+2].ts = hz_s[3*j+2].ps;
			end
		end
	end

	always_comb begin
		cv = ctl_s[NH].swap ? hz_s[NH].ts : hz_s[NH].tc;
		sv = ctl_s[NH].swap ? hz_s[NH].tc : hz_s[NH].ts;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NH+2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// fold to an octant
			q_s1    <= a[31:30];
			swap_s1 <= a[29];
			g_s1    <= a[29] ? 30'((31'd1 << 30) - 31'(a[29:0])) : a[29:0];
			neg1_s1 <= (a[31:30] == 2'd1 || a[31:30] == 2'd2) ^ !a[31];
			sb_s1   <= sb_in;
			// radians in Q30
			ctl_s2.x    <= TW'(g_s1) + TW'((xp + (62'd1 << 31)) >> 32);
			ctl_s2.x2   <= '0;
			ctl_s2.q    <= q_s1;
			ctl_s2.swap <= swap_s1;
			ctl_s2.neg1 <= neg1_s1;
			sb_s2       <= sb_s1;
			ctl_s[0]    <= '{x: ctl_s2.x,
				x2: TW'((62'(ctl_s2.x) * 62'(ctl_s2.x)) >> 30),
				q: ctl_s2.q, swap: ctl_s2.swap, neg1: ctl_s2.neg1};
			hz_s[0]     <= '{tc: Q30_ONE, ts: Q30_ONE, default: '0};
			sb_s[0]     <= sb_s2;
			for (int k = 0; k < NH; k++) begin
				hz_s[k+1]  <= hz_n[k];
				ctl_s[k+1] <= ctl_s[k];
				sb_s[k+1]  <= sb_s[k];
			end
			res_q_s.m1   <= ctl_s[NH].q[0] ? sv : cv;
			res_q_s.m2   <= ctl_s[NH].q[0] ? cv : sv;
			res_q_s.neg1 <= ctl_s[NH].neg1;
			sb_out_s     <= sb_s[NH];
		end
	end

	assign out_valid = vld_s[NH+3];
	assign res       = res_q_s;
	assign sb_out    = sb_out_s;

endmodule

### sv/box_muller_gaussian_pair_top.sv
// Box-Muller Gaussian pair generator.
// Input stream (s_tvalid/s_tready/s_tdata): one transaction carries two uniform
// fractions, u_radius in tdata[31:0] and u_angle in tdata[63:32], each k/2^32.
// Output stream (m_tvalid/m_tready/m_tdata): one transaction per input, the
// cosine branch sample gauss_first in tdata[15:0] and the sine branch sample
// gauss_second in tdata[31:16], both signed Q3.12 (OUT_FRAC_BITS), saturated.
// Throughput: one pair per clock, back to back, with no bubbles inserted, while the
// receiver keeps up. The pipeline depth is set by the 30 squaring stages of the
// log2 unit, one stage per root bit of the square root (RW = 27 at the default
// width) and the 19-stage sine/cosine pipeline with its Horner steps, plus the
// product and rounding stages here.
// When the receiver stalls with a result pending, the whole pipeline freezes
// in place and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits, so the pipeline comes up empty and m_tvalid low.
`include "box_muller_gaussian_pair_top_assert.svh"

module box_muller_gaussian_pair_top #(
	parameter int IN_BITS = bmg_pkg::IN_BITS_DEF,
	parameter int OUT_FRAC_BITS = bmg_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] u_radius, [63:32] u_angle
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [15:0] gauss_first, [31:16] gauss_second
);
	import bmg_pkg::*;

	localparam int VW = $clog2(IN_BITS + 1) + 31;
	localparam int RW = (VW + 17) / 2;
	localparam int PW = RW + TW;
	localparam int SH = 53 - OUT_FRAC_BITS;

	logic               en;
	logic [IN_BITS-1:0] k1, k2;
	logic [31:0]        a_in;
	logic               neg2_in;

	logic               log_v;
	logic [VW-1:0]      v;
	logic [32:0]        log_sb;
	logic               sq_v;
	logic [RW-1:0]      r;
	logic [32:0]        sq_sb;
	logic               trig_v;
	trig_res_t          trig;
	logic [RW:0]        trig_sb;

	logic               mul_v_s1;
	logic [PW-1:0]      p1_s1, p2_s1;
	logic               neg1_s1, neg2_s1;
	logic               out_v_s2;
	logic [15:0]        first_s2, second_s2;

	// the whole pipeline advances unless a finished result is held back
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	assign k1 = IN_BITS'(s_tdata[31:0]);
	assign k2 = IN_BITS'(s_tdata[63:32]);

	// angle as Q32 turns
	generate
		if (IN_BITS >= 32) begin : g_ang_wide
			assign a_in = k2[IN_BITS-1 -: 32];
		end else begin : g_ang_narrow
			assign a_in = {k2, {(32-IN_BITS){1'b0}}};
		end
	endgenerate

	// sine branch sign: lower half-circle, flipped when u_radius is below one half
	assign neg2_in = a_in[31] ^ !k1[IN_BITS-1];

	bmg_log #(.IN_BITS(IN_BITS), .SBW(33), .VW(VW)) u_log (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_tvalid && s_tready), .k(k1), .sb_in({a_in, neg2_in}),
		.out_valid(log_v), .v(v), .sb_out(log_sb)
	);

	bmg_sqrt #(.VW(VW), .SBW(33)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(log_v), .v(v), .sb_in(log_sb),
		.out_valid(sq_v), .r(r), .sb_out(sq_sb)
	);

	bmg_trig #(.SBW(RW + 1)) u_trig (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(sq_v), .a(sq_sb[32:1]), .sb_in({r, sq_sb[0]}),
		.out_valid(trig_v), .res(trig), .sb_out(trig_sb)
	);

	// round half away from zero, then saturate to the signed 16-bit range
	function automatic logic [15:0] finish(input logic [PW-1:0] p, input logic neg);
		logic [PW:0] sum, mag;
		logic [16:0] sat;
		sum = {1'b0, p} + ((PW+1)'(1) << (SH - 1));
		mag = sum >> SH;
		if (neg) begin
			sat = (mag > (PW+1)'(32768)) ? 17'd32768 : 17'(mag);
			finish = 16'(17'd0 - sat);
		end else begin
			sat = (mag > (PW+1)'(32767)) ? 17'd32767 : 17'(mag);
			finish = 16'(sat);
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s1 <= 1'b0;
			out_v_s2 <= 1'b0;
		end else if (en) begin
			mul_v_s1 <= trig_v;
			out_v_s2 <= mul_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1     <= PW'(trig_sb[RW:1]) * PW'(trig.m1);
			p2_s1     <= PW'(trig_sb[RW:1]) * PW'(trig.m2);
			neg1_s1   <= trig.neg1;
			neg2_s1   <= trig_sb[0];
			first_s2  <= finish(p1_s1, neg1_s1);
			second_s2 <= finish(p2_s1, neg2_s1);
		end
	end

	assign m_tvalid = out_v_s2;
	assign m_tdata  = {second_s2, first_s2};

	`BMG_ASSERT_NEXT(a_stall_freezes, !en, $stable(mul_v_s1), "product stage moved during stall")
	`BMG_ASSERT_NEXT(a_product_lands, en && mul_v_s1, m_tvalid, "product lost before output")
	`BMG_ASSERT_NOW(a_trig_bound, trig_v, trig.m1 <= Q30_ONE && trig.m2 <= Q30_ONE,
		"trig magnitude above one")

endmodule
